// ===== src/pgrb_pkg.sv =====
// ----------------------------------------------------------------------------
// pgrb_pkg
// Shared types and constants of the planar glyph blitter: item words,
// write words, the front-to-back task word, opcodes and colors.
// ----------------------------------------------------------------------------
package pgrb_pkg;

   // Item opcodes; code 3 means nothing and is dropped
   localparam logic [1:0] OP_MAP_LOAD = 2'd0;
   localparam logic [1:0] OP_ROW_LOAD = 2'd1;
   localparam logic [1:0] OP_DRAW     = 2'd2;

   // Colors by reveal distance
   localparam logic [7:0] COLOR_NEWEST = 8'hFF;
   localparam logic [7:0] COLOR_BEHIND = 8'hFE;
   localparam logic [7:0] COLOR_OLDER  = 8'hFD;

   // Cap on writes caused by one character
   localparam int MAX_WRITES = 64;

   // Store sizes
   localparam int MAP_DEPTH       = 256;
   localparam int ROW_STORE_DEPTH = 1024;

   // Task queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [9:0]  table_address;
      logic [7:0]  table_data;
      logic [7:0]  character;
      logic [9:0]  line_x;
      logic [8:0]  line_y;
      logic [7:0]  char_index;
      logic [15:0] line_start;
      logic [15:0] reveal_cursor;
   } pgrb_req_type;

   typedef struct packed {
      logic [1:0]  plane_index;
      logic [15:0] byte_address;
      logic [7:0]  pixel_color;
      logic        last_write;
   } pgrb_rsp_type;

   // Row load: row_addr/row_data give the store write.
   // Draw: row_addr is the first glyph row, base/shift/color set the writes.
   typedef struct packed {
      logic        is_draw;
      logic [9:0]  row_addr;
      logic [7:0]  row_data;
      logic [1:0]  shift;
      logic [15:0] base;
      logic [7:0]  color;
   } pgrb_task_type;

   // Count set bits of one glyph row
   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] c;
      c = 4'd0;
      for (int i = 0; i < 8; i++) begin
         c = c + {3'b000, v[i]};
      end
      return c;
   endfunction

endpackage

// ===== src/pgrb_front.sv =====
// ----------------------------------------------------------------------------
// pgrb_front
// Accepts item words, keeps the character-to-glyph map, classifies each
// draw (revealed, has a glyph) and pushes row loads and live draws as
// task words toward the back end.
// ----------------------------------------------------------------------------
module pgrb_front #(
   parameter int ROW_BYTES    = 80,
   parameter int GLYPH_HEIGHT = 8,
   parameter int GLYPH_COUNT  = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pgrb_pkg::pgrb_req_type  req_data,
   input  logic [15:0]             frame_base,
   output logic                    push_valid,
   input  logic                    push_ready,
   output pgrb_pkg::pgrb_task_type push_data
);
   import pgrb_pkg::*;

   logic [7:0]   glyph_map [MAP_DEPTH];
   logic [7:0]   map_rd_ff;
   pgrb_req_type s1_item_ff;
   logic         s1_valid_ff, s1_valid_in;
   logic         accept, need_push, s1_free;
   logic         visible, glyph_ok, is_draw;
   logic [15:0]  reveal_gap, row_term, base;
   logic [7:0]   color;
   logic [9:0]   row_base;

   assign accept = req_valid && !req_stall;

   // Map store: write on map load, registered read of the drawn character
   always_ff @(posedge clock) begin
      if (accept && req_data.opcode == OP_MAP_LOAD &&
          req_data.table_address[9:8] == 2'b00) begin
         glyph_map[req_data.table_address[7:0]] <= req_data.table_data;
      end
      if (accept) begin
         map_rd_ff  <= glyph_map[req_data.character];
         s1_item_ff <= req_data;
      end
   end

   // Classify the held word
   always_comb begin
      reveal_gap = s1_item_ff.reveal_cursor
                   - (s1_item_ff.line_start + {8'b0, s1_item_ff.char_index});
      visible  = !reveal_gap[15];
      if (reveal_gap == 16'd0) begin
         color = COLOR_NEWEST;
      end else if (reveal_gap == 16'd1) begin
         color = COLOR_BEHIND;
      end else begin
         color = COLOR_OLDER;
      end
      glyph_ok = !map_rd_ff[7] && ({1'b0, map_rd_ff[6:0]} < 8'(GLYPH_COUNT));
      row_term = 16'({7'b0, s1_item_ff.line_y} * 16'(ROW_BYTES));
      base     = frame_base + row_term + {8'b0, s1_item_ff.line_x[9:2]}
                 + {7'b0, s1_item_ff.char_index, 1'b0};
      row_base = 10'({3'b0, map_rd_ff[6:0]} * 10'(GLYPH_HEIGHT));
      is_draw  = (s1_item_ff.opcode == OP_DRAW);
      case (s1_item_ff.opcode)
         OP_ROW_LOAD: need_push = 1'b1;
         OP_DRAW:     need_push = visible && glyph_ok;
         default:     need_push = 1'b0;
      endcase
   end

   // Task word toward the back end
   always_comb begin
      push_data.is_draw  = is_draw;
      push_data.row_addr = is_draw ? row_base : s1_item_ff.table_address;
      push_data.row_data = s1_item_ff.table_data;
      push_data.shift    = s1_item_ff.line_x[1:0];
      push_data.base     = base;
      push_data.color    = color;
   end

   assign push_valid = s1_valid_ff && need_push;
   assign s1_free    = !s1_valid_ff || !need_push || push_ready;
   assign req_stall  = !s1_free;

   // Hold the stage until its word is pushed or dropped
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   a_push_kind: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (s1_item_ff.opcode == OP_ROW_LOAD || s1_item_ff.opcode == OP_DRAW))
      else $error("front pushed a task for a load map or unused opcode");

endmodule

// ===== src/pgrb_queue.sv =====
// ----------------------------------------------------------------------------
// pgrb_queue
// Short task queue that decouples the classifying front from the
// write-generating back end.
// ----------------------------------------------------------------------------
module pgrb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  pgrb_pkg::pgrb_task_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output pgrb_pkg::pgrb_task_type pop_data
);
   import pgrb_pkg::*;

   pgrb_task_type       slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/pgrb_back.sv =====
// ----------------------------------------------------------------------------
// pgrb_back
// Owns the glyph row store. Applies row loads, and for each draw task
// fetches the glyph rows, counts their set bits, then scans plane group,
// row and half, emitting one write word per set bit, up to MAX_WRITES.
// ----------------------------------------------------------------------------
module pgrb_back #(
   parameter int ROW_BYTES    = 80,
   parameter int GLYPH_HEIGHT = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  pgrb_pkg::pgrb_task_type pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pgrb_pkg::pgrb_rsp_type  rsp_data
);
   import pgrb_pkg::*;

   localparam int RW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam int CW = $clog2(GLYPH_HEIGHT + 1);
   localparam int TW = $clog2(8 * GLYPH_HEIGHT + 1);
   localparam int EW = $clog2(MAX_WRITES + 1);
   localparam int NW = (TW > EW) ? TW : EW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_EMIT = 3'b100
   } pgrb_state_type;

   pgrb_state_type state_ff, state_in;
   pgrb_task_type  task_ff;
   logic [7:0]     glyph_rows [ROW_STORE_DEPTH];
   logic [7:0]     rd_data_ff;
   logic [9:0]     idx_ff;
   logic [CW-1:0]  ld_cnt_ff;
   logic           rd_valid_ff;
   logic [RW-1:0]  rd_idx_ff;
   logic [7:0]     rows_ff [GLYPH_HEIGHT];
   logic [TW-1:0]  total_ff;
   logic [EW-1:0]  n_ff;
   logic [1:0]     p_ff;
   logic [RW-1:0]  r_ff;
   logic           half_ff;
   logic [15:0]    row_off_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   pgrb_rsp_type   rsp_data_ff, rsp_data_in;

   logic           take, row_we, issue, fetch_done;
   logic [2:0]     sum3;
   logic [7:0]     cur_row;
   logic           bit_set, out_free, emit, step, is_last, row_wrap;
   logic [15:0]    addr;

   assign pop_ready  = (state_ff == ST_IDLE);
   assign take       = pop_valid && pop_ready;
   assign row_we     = take && !pop_data.is_draw;
   assign issue      = (state_ff == ST_LOAD) && (ld_cnt_ff < CW'(GLYPH_HEIGHT));
   assign fetch_done = rd_valid_ff && (rd_idx_ff == RW'(GLYPH_HEIGHT - 1));

   // Glyph row store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (row_we) begin
         glyph_rows[pop_data.row_addr] <= pop_data.row_data;
      end
      rd_data_ff <= glyph_rows[idx_ff];
   end

   // Scan position and the write it makes
   always_comb begin
      sum3     = {1'b0, task_ff.shift} + {1'b0, p_ff};
      cur_row  = rows_ff[r_ff];
      bit_set  = cur_row[{~half_ff, ~p_ff}];
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = (state_ff == ST_EMIT) && bit_set && out_free;
      step     = (state_ff == ST_EMIT) && (!bit_set || out_free);
      is_last  = ((NW'(n_ff) + NW'(1)) == NW'(total_ff))
                 || (n_ff == EW'(MAX_WRITES - 1));
      row_wrap = (r_ff == RW'(GLYPH_HEIGHT - 1));
      addr     = task_ff.base + {15'b0, sum3[2]} + row_off_ff + {15'b0, half_ff};
      rsp_data_in.plane_index  = sum3[1:0];
      rsp_data_in.byte_address = addr;
      rsp_data_in.pixel_color  = task_ff.color;
      rsp_data_in.last_write   = is_last;
   end

   // Sequence: idle, fetch rows, scan
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && pop_data.is_draw) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (fetch_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (total_ff == '0 || (emit && is_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath: latch task, fetch rows, count bits, advance scan
   always_ff @(posedge clock) begin
      if (take && pop_data.is_draw) begin
         task_ff    <= pop_data;
         idx_ff     <= pop_data.row_addr;
         ld_cnt_ff  <= '0;
         total_ff   <= '0;
         n_ff       <= '0;
         p_ff       <= 2'd0;
         r_ff       <= '0;
         half_ff    <= 1'b0;
         row_off_ff <= 16'd0;
      end else begin
         if (issue) begin
            idx_ff    <= idx_ff + 10'd1;
            ld_cnt_ff <= ld_cnt_ff + CW'(1);
            rd_idx_ff <= ld_cnt_ff[RW-1:0];
         end
         if (rd_valid_ff) begin
            rows_ff[rd_idx_ff] <= rd_data_ff;
            total_ff           <= total_ff + TW'(pop8(rd_data_ff));
         end
         if (emit) begin
            n_ff <= n_ff + EW'(1);
         end
         if (step) begin
            if (!half_ff) begin
               half_ff <= 1'b1;
            end else begin
               half_ff <= 1'b0;
               if (row_wrap) begin
                  r_ff       <= '0;
                  row_off_ff <= 16'd0;
                  p_ff       <= p_ff + 2'd1;
               end else begin
                  r_ff       <= r_ff + RW'(1);
                  row_off_ff <= row_off_ff + 16'(ROW_BYTES);
               end
            end
         end
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      emit |-> (n_ff < EW'(MAX_WRITES)))
      else $error("write emitted beyond the per-character cap");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      emit |-> (NW'(n_ff) < NW'(total_ff)))
      else $error("write emitted beyond the counted glyph bits");

   a_fetch_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !rd_valid_ff)
      else $error("row fetch still in flight during scan");

endmodule

// ===== src/planar_glyph_reveal_blitter.sv =====
// ----------------------------------------------------------------------------
// planar_glyph_reveal_blitter
// Draws one text character into a four-plane framebuffer.
//
// Request channel (req_valid/req_stall/req_data) takes map loads, glyph
// row loads and draw words; a word is taken when req_valid is high and
// req_stall is low. Map loads finish in the front; row loads are written
// by the back end. A draw that is unrevealed or maps to no glyph is
// dropped in the front and produces nothing.
// A live draw passes the front stage and the queue; the back end then
// fetches its GLYPH_HEIGHT rows and scans up to 8*GLYPH_HEIGHT bit
// positions, one step per empty position and one per write, ending at
// the last write. The back end handles one task at a time; a four-deep
// queue lets the front keep taking words.
// Response channel (rsp_valid/rsp_stall/rsp_data) carries one write per
// word, last_write on the final one. While rsp_stall is high and a word
// is valid, the word holds and the scan waits on set bits. csr_ready is
// always high; write frame_base only while idle. Reset clears control
// state and frame_base; map and row stores hold nothing defined until
// loaded.
// ----------------------------------------------------------------------------
module planar_glyph_reveal_blitter #(
   parameter int ROW_BYTES    = 80,
   parameter int GLYPH_HEIGHT = 8,
   parameter int GLYPH_COUNT  = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pgrb_pkg::pgrb_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pgrb_pkg::pgrb_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);
   import pgrb_pkg::*;

   logic [15:0]   frame_base_ff, frame_base_in;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   pgrb_task_type push_data, pop_data;

   // Frame base register
   assign csr_ready     = 1'b1;
   assign frame_base_in = (csr_valid && csr_ready) ? csr_data : frame_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= 16'd0;
      end else begin
         frame_base_ff <= frame_base_in;
      end
   end

   pgrb_front #(
      .ROW_BYTES    (ROW_BYTES),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .frame_base (frame_base_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pgrb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pgrb_back #(
      .ROW_BYTES    (ROW_BYTES),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the planar glyph blitter. Loads map entries and
// glyph rows, then draws characters under several framebuffer bases, with
// random gaps on the request side and random stalls on the write side. Every
// accepted write is checked field by field against a predictor kept here.
// ----------------------------------------------------------------------------
module tb_top;
   import pgrb_pkg::*;

   localparam int ROW_BYTES     = 80;
   localparam int GLYPH_HEIGHT  = 8;
   localparam int GLYPH_COUNT   = 128;
   localparam int IDLE_PCT      = 23;
   localparam int SETTLE_CYCLES = 600;
   localparam int CYCLE_LIMIT   = 400000;

   // Opcode that the block drops without effect
   localparam logic [1:0] OP_NONE = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pgrb_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pgrb_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;

   // Stimulus words waiting for the driver, and writes still owed by the block
   pgrb_req_type req_words[$];
   pgrb_rsp_type pending_writes[$];

   // Predictor copy of the block's stores and base register
   logic [7:0]  map_mirror[256];
   logic [7:0]  row_mirror[1024];
   logic [15:0] frame_mirror = '0;

   // What the generator has loaded so far, to keep draws on written entries
   bit          gen_map_set[256];
   logic [7:0]  gen_map[256];
   bit          gen_row_set[1024];

   bit calm = 1'b0;
   int words_left = 0;
   int words_taken = 0;
   int draws_taken = 0;
   int writes_seen = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   planar_glyph_reveal_blitter #(
      .ROW_BYTES   (ROW_BYTES),
      .GLYPH_HEIGHT(GLYPH_HEIGHT),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Work out the framebuffer writes that one accepted word causes
   function automatic void predict_glyph_writes(input pgrb_req_type w);
      logic [15:0]  gap;
      logic [7:0]   color;
      logic [7:0]   bits;
      int           glyph;
      int           shift;
      int unsigned  line_base;
      int unsigned  col;
      int           n;
      bit           have_held;
      pgrb_rsp_type held;
      pgrb_rsp_type wr;
      n = 0;
      have_held = 1'b0;
      held = '0;
      case (w.opcode)
         OP_MAP_LOAD: begin
            if (w.table_address < 256) map_mirror[w.table_address[7:0]] = w.table_data;
         end
         OP_ROW_LOAD: begin
            row_mirror[w.table_address] = w.table_data;
         end
         OP_DRAW: begin
            gap = w.reveal_cursor - (w.line_start + {8'h00, w.char_index});
            glyph = int'(map_mirror[w.character]);
            if (!gap[15] && glyph < GLYPH_COUNT) begin
               draws_taken++;
               color = (gap == 16'd0) ? COLOR_NEWEST :
                       (gap == 16'd1) ? COLOR_BEHIND : COLOR_OLDER;
               shift = int'(w.line_x[1:0]);
               line_base = frame_mirror + w.line_y * ROW_BYTES + (w.line_x >> 2)
                           + 2 * w.char_index;
               // Walk plane groups, then rows, left byte before right byte
               for (int p = 0; p < 4; p++) begin
                  col = line_base + ((shift + p >= 4) ? 1 : 0);
                  for (int r = 0; r < GLYPH_HEIGHT; r++) begin
                     bits = row_mirror[(glyph * GLYPH_HEIGHT + r) % 1024];
                     for (int half = 0; half < 2; half++) begin
                        if (bits[(half ? 3 : 7) - p] && n < MAX_WRITES) begin
                           wr.plane_index  = 2'(shift + p);
                           wr.byte_address = 16'(col + r * ROW_BYTES + half);
                           wr.pixel_color  = color;
                           wr.last_write   = 1'b0;
                           if (have_held) pending_writes.push_back(held);
                           held = wr;
                           have_held = 1'b1;
                           n++;
                        end
                     end
                  end
               end
               // Flag the final write of this character
               if (have_held) begin
                  held.last_write = 1'b1;
                  pending_writes.push_back(held);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 20) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   // Compare one accepted write with the oldest one owed
   task automatic check_write(input pgrb_rsp_type got);
      pgrb_rsp_type want;
      writes_seen++;
      if (pending_writes.size() == 0) begin
         report_mismatch($sformatf("unexpected write plane %0d addr %h color %h last %0d",
            got.plane_index, got.byte_address, got.pixel_color, got.last_write));
      end else begin
         want = pending_writes.pop_front();
         if (got.plane_index !== want.plane_index)
            report_mismatch($sformatf("write %0d plane_index %0d, want %0d",
               writes_seen, got.plane_index, want.plane_index));
         if (got.byte_address !== want.byte_address)
            report_mismatch($sformatf("write %0d byte_address %h, want %h",
               writes_seen, got.byte_address, want.byte_address));
         if (got.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("write %0d pixel_color %h, want %h",
               writes_seen, got.pixel_color, want.pixel_color));
         if (got.last_write !== want.last_write)
            report_mismatch($sformatf("write %0d last_write %0d, want %0d",
               writes_seen, got.last_write, want.last_write));
      end
   endtask

   // Present words; predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_glyph_writes(req_data);
            words_left--;
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_data  <= req_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Take writes and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_write(rsp_data);
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic bit glyph_loaded(input int g);
      for (int r = 0; r < GLYPH_HEIGHT; r++) begin
         if (!gen_row_set[(g * GLYPH_HEIGHT + r) % 1024]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // A character is safe to draw once its map entry and, if live, its rows exist
   function automatic bit drawable(input int ch);
      if (!gen_map_set[ch]) return 1'b0;
      if (gen_map[ch] >= GLYPH_COUNT) return 1'b1;
      return glyph_loaded(int'(gen_map[ch]));
   endfunction

   function automatic int pick_char();
      int start;
      start = $urandom_range(255);
      for (int k = 0; k < 256; k++) begin
         if (drawable((start + k) % 256)) return (start + k) % 256;
      end
      return -1;
   endfunction

   function automatic pgrb_req_type random_word();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(pgrb_req_type)-1:0];
   endfunction

   function automatic pgrb_req_type load_word(input logic [1:0] op, input logic [9:0] addr,
                                              input logic [7:0] data);
      pgrb_req_type w;
      w = random_word();
      w.opcode        = op;
      w.table_address = addr;
      w.table_data    = data;
      return w;
   endfunction

   // Place the reveal cursor at a given distance past this character
   function automatic pgrb_req_type aim(input pgrb_req_type w, input logic [15:0] gap);
      w.reveal_cursor = w.line_start + {8'h00, w.char_index} + gap;
      return w;
   endfunction

   function automatic pgrb_req_type draw_word(input int ch, input logic [15:0] gap);
      pgrb_req_type w;
      w = random_word();
      w.opcode    = OP_DRAW;
      w.character = 8'(ch);
      return aim(w, gap);
   endfunction

   // Mostly revealed, weighted toward the two newest colors
   function automatic logic [15:0] pick_distance();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return 16'd0;
      if (roll < 55) return 16'd1;
      if (roll < 85) return 16'($urandom_range(2, 16'h7FFF));
      return 16'($urandom_range(16'h8000, 16'hFFFF));
   endfunction

   function automatic logic [7:0] random_row();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Queue a word and track what it loads
   task automatic push_word(input pgrb_req_type w);
      if (w.opcode == OP_MAP_LOAD && w.table_address < 256) begin
         gen_map[w.table_address[7:0]]     = w.table_data;
         gen_map_set[w.table_address[7:0]] = 1'b1;
      end
      if (w.opcode == OP_ROW_LOAD) gen_row_set[w.table_address] = 1'b1;
      words_left++;
      req_words.push_back(w);
   endtask

   task automatic write_frame_base(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      frame_mirror = value;
      csr_valid <= 1'b0;
   endtask

   // Hold until every word is taken and every write is back, then let it settle
   task automatic wait_drained();
      while (words_left != 0 || pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic directed_words();
      pgrb_req_type w;
      // Full glyph 0 gives the most writes; the last glyph is blank and
      // reaches the top of the row store
      for (int k = 0; k < GLYPH_HEIGHT; k++)
         push_word(load_word(OP_ROW_LOAD, 10'(k), 8'hFF));
      for (int k = 0; k < GLYPH_HEIGHT; k++)
         push_word(load_word(OP_ROW_LOAD, 10'((GLYPH_COUNT - 1) * GLYPH_HEIGHT + k),
                             8'h00));
      push_word(load_word(OP_MAP_LOAD, 10'd0, 8'h00));
      push_word(load_word(OP_MAP_LOAD, 10'd255, 8'(GLYPH_COUNT - 1)));
      push_word(load_word(OP_MAP_LOAD, 10'd65, 8'h80));
      // Out-of-range map load must not land on entry 255
      push_word(load_word(OP_MAP_LOAD, 10'd1023, 8'h00));

      w = draw_word(0, 16'd0);
      w.line_x = '1; w.line_y = '1; w.char_index = '1; w.line_start = '1;
      push_word(aim(w, 16'd0));
      w = draw_word(0, 16'd1);
      w.line_x = '0; w.line_y = '0; w.char_index = '0; w.line_start = '0;
      push_word(aim(w, 16'd1));
      w = draw_word(0, 16'd2);
      w.line_x[1:0] = 2'd3;
      push_word(aim(w, 16'd2));
      push_word(draw_word(0, 16'h7FFF));
      push_word(draw_word(255, 16'd0));
      push_word(draw_word(65, 16'd0));
      push_word(draw_word(0, 16'h8000));
      w = random_word();
      w.opcode = OP_NONE;
      push_word(w);
   endtask

   task automatic random_words(input int goal);
      pgrb_req_type w;
      int made;
      int ch;
      int g;
      int reps;
      int roll;
      made = 0;
      while (made < goal) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            // Load a glyph, point a character at it, then draw that character
            g  = $urandom_range(GLYPH_COUNT - 1);
            ch = $urandom_range(255);
            if (!glyph_loaded(g) || $urandom_range(1)) begin
               for (int k = 0; k < GLYPH_HEIGHT; k++) begin
                  push_word(load_word(OP_ROW_LOAD, 10'(g * GLYPH_HEIGHT + k), random_row()));
                  made++;
               end
            end
            if ($urandom_range(9) == 0)
               push_word(load_word(OP_MAP_LOAD, 10'(ch), 8'($urandom | 32'h80)));
            else push_word(load_word(OP_MAP_LOAD, 10'(ch), 8'(g)));
            made++;
            reps = $urandom_range(1, 3);
            for (int k = 0; k < reps; k++) begin
               push_word(draw_word(ch, pick_distance()));
               made++;
            end
         end else if (roll < 85) begin
            ch = pick_char();
            if (ch >= 0) begin
               push_word(draw_word(ch, pick_distance()));
               made++;
            end
         end else begin
            // Noise: any opcode, loads anywhere, draws only on written entries
            w = random_word();
            if (w.opcode == OP_DRAW) begin
               ch = pick_char();
               if (ch < 0) w.opcode = OP_NONE;
               else w = draw_word(ch, 16'($urandom));
            end
            push_word(w);
            if (w.opcode != OP_NONE && !(w.opcode == OP_MAP_LOAD && w.table_address > 255))
               made++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_frame_base(16'hFFFF);
      directed_words();
      wait_drained();

      write_frame_base(16'h0000);
      random_words(100);
      wait_drained();

      // Run this phase with no gaps and no stalls
      calm = 1'b1;
      write_frame_base(16'($urandom));
      random_words(100);
      wait_drained();

      calm = 1'b0;
      write_frame_base(16'($urandom));
      random_words(100);
      wait_drained();

      $display("Covered %0d words, %0d drawn characters, %0d writes checked",
               words_taken, draws_taken, writes_seen);
      $display("across four framebuffer bases including both extremes");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pgrb_pkg.sv
src/pgrb_front.sv
src/pgrb_queue.sv
src/pgrb_back.sv
src/planar_glyph_reveal_blitter.sv
tb/tb_top.sv
